// File: sv/wpm_pkg.sv
// Package for the wildcard pattern matcher: item kind codes, wildcard bytes,
// the default pattern capacity and the struct that feeds the match cell.
// No dependencies.
package wpm_pkg;

  localparam int unsigned MaxPatternDef = 64;

  localparam logic [1:0] KIND_PATTERN = 2'd0;
  localparam logic [1:0] KIND_TEXT    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  // Operands of one step of the row update.
  typedef struct packed {
    logic       restart;  // build the restart row instead of a text update
    logic [7:0] pat;      // pattern byte of this column
    logic [7:0] text;     // current text byte
    logic       above;    // old row bit of this column
    logic       diag;     // old row bit of the previous column
    logic       left;     // new row bit of the previous column
  } wpm_cell_in_t;

endpackage

// File: sv/wpm_cell.sv
// Match cell of the wildcard pattern matcher: works out one new row bit.
// Depends on wpm_pkg.
module wpm_cell import wpm_pkg::*; (
  input  wpm_cell_in_t cell_i,
  output logic         next_o
);

  always_comb begin
    if (cell_i.restart) begin
      // The restart row holds while every pattern byte so far is a star.
      next_o = cell_i.left && (cell_i.pat == STAR_BYTE);
    end else begin
      priority if (cell_i.pat == STAR_BYTE) begin
        next_o = cell_i.above || cell_i.left;
      end else if ((cell_i.pat == ANY_BYTE) || (cell_i.pat == cell_i.text)) begin
        next_o = cell_i.diag;
      end else begin
        next_o = 1'b0;
      end
    end
  end

endmodule

// File: sv/wildcard_pattern_matcher.sv
// Wildcard pattern matcher, one item at a time. A text or restart request sweeps the stored
// pattern column by column through the one memory read port and then gives a result; with
// an empty pattern it goes straight to the result step. A pattern request sweeps the same
// way with no result. No new request is taken until the sweep is through, and a result
// left waiting holds the block in its last step. Depends on wpm_pkg and wpm_cell.
// Reset clears length, overflow flag and control and sets row bit 0; memory is not cleared.
module wildcard_pattern_matcher import wpm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MaxPatternDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] symbol_i,
  input  logic       first_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       matched_o,
  output logic       pattern_overflow_o
);

  // Address width of the memory and width of the length count.
  localparam int unsigned AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // Each memory word holds pattern byte k in its low byte and row bit k+1 in
  // its top bit, so that one read gives everything a column step needs.
  logic [8:0]    mem_q [MAX_PATTERN];
  logic [8:0]    rd_q;

  logic [1:0]    state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic          ovf_q, ovf_d;
  logic          row0_q, row0_d;
  logic [AW-1:0] k_q, k_d;
  logic          diag_q, diag_d;
  logic          left_q, left_d;
  logic          restart_q, restart_d;
  logic          want_q, want_d;
  logic [7:0]    text_q, text_d;
  logic          out_valid_q, out_valid_d;
  logic          matched_q, matched_d;
  logic          out_ovf_q, out_ovf_d;

  logic          accept;
  logic [LW-1:0] eff_len;
  logic          room;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [8:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          last;
  logic          next_bit;
  wpm_cell_in_t  cell_in;

  assign accept  = in_valid_i && in_ready_o;
  assign eff_len = first_i ? '0 : len_q;
  assign room    = eff_len < LW'(MAX_PATTERN);
  assign last    = (LW'(k_q) + LW'(1)) == len_q;

  assign cell_in.restart = restart_q;
  assign cell_in.pat     = rd_q[7:0];
  assign cell_in.text    = text_q;
  assign cell_in.above   = rd_q[8];
  assign cell_in.diag    = diag_q;
  assign cell_in.left    = left_q;

  wpm_cell u_cell (
    .cell_i (cell_in),
    .next_o (next_bit)
  );

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    row0_d      = row0_q;
    k_d         = k_q;
    diag_d      = diag_q;
    left_d      = left_q;
    restart_d   = restart_q;
    want_d      = want_q;
    text_d      = text_q;
    out_valid_d = out_valid_q;
    matched_d   = matched_q;
    out_ovf_d   = out_ovf_q;
    wr_en       = 1'b0;
    wr_addr     = k_q;
    wr_data     = {next_bit, rd_q[7:0]};
    rd_en       = 1'b0;
    rd_addr     = '0;

    // The waiting result leaves whenever the far side takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          text_d = symbol_i;
          k_d    = '0;
          unique case (kind_i)
            KIND_PATTERN: begin
              // Append the byte if there is room, else flag overflow; then rebuild the restart row.
              if (room) begin
                wr_en   = 1'b1;
                wr_addr = eff_len[AW-1:0];
                wr_data = {1'b0, symbol_i};
                len_d   = eff_len + LW'(1);
              end else begin
                len_d = eff_len;
              end
              ovf_d     = (first_i ? 1'b0 : ovf_q) || !room;
              restart_d = 1'b1;
              want_d    = 1'b0;
              row0_d    = 1'b1;
              left_d    = 1'b1;
              state_d   = ST_ISSUE;
            end
            KIND_TEXT: begin
              // Column 0 can never match a non-empty text.
              restart_d = 1'b0;
              want_d    = 1'b1;
              diag_d    = row0_q;
              row0_d    = 1'b0;
              left_d    = 1'b0;
              state_d   = (len_q == '0) ? ST_FIN : ST_ISSUE;
            end
            KIND_RESTART: begin
              restart_d = 1'b1;
              want_d    = 1'b1;
              row0_d    = 1'b1;
              left_d    = 1'b1;
              state_d   = (len_q == '0) ? ST_FIN : ST_ISSUE;
            end
            default: begin
              // Unknown kind: the pattern and the row stay as they are and nothing is reported.
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_ISSUE: begin
        rd_en   = 1'b1;
        rd_addr = '0;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        // Column k_q+1 is updated while column k_q+2 is being fetched.
        wr_en  = 1'b1;
        diag_d = rd_q[8];
        left_d = next_bit;
        if (last) begin
          state_d = ST_FIN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = k_q + AW'(1);
          k_d     = k_q + AW'(1);
        end
      end
      ST_FIN: begin
        // The last new row bit is the whole-pattern answer.
        if (!want_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          matched_d   = left_q;
          out_ovf_d   = ovf_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      row0_q      <= 1'b1;
      out_valid_q <= 1'b0;
      want_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      row0_q      <= row0_d;
      out_valid_q <= out_valid_d;
      want_q      <= want_d;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    diag_q    <= diag_d;
    left_q    <= left_d;
    restart_q <= restart_d;
    text_q    <= text_d;
    matched_q <= matched_d;
    out_ovf_q <= out_ovf_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign in_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign pattern_overflow_o = out_ovf_q;

endmodule

// File: sv/wpm_checker.sv
// Port-level checker for the wildcard pattern matcher, bound to the top level.
// Depends on wpm_pkg and wildcard_pattern_matcher.
module wpm_checker import wpm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] kind_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       matched_o,
  input logic       pattern_overflow_o
);

  // A result that waits holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(matched_o)
                                    && $stable(pattern_overflow_o))
    else $error("waiting result changed or vanished");

  // A result never appears in the cycle right after a request is taken.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // A text request keeps the block busy for its sweep.
  a_text_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_TEXT) |=> !in_ready_o)
    else $error("block ready straight after a text request");

  // An unknown kind is ignored and the block stays ready.
  a_unknown_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i != KIND_PATTERN) && (kind_i != KIND_TEXT)
    && (kind_i != KIND_RESTART) |=> in_ready_o)
    else $error("unknown kind stalled the block");

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .kind_i             (kind_i),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .matched_o          (matched_o),
  .pattern_overflow_o (pattern_overflow_o)
);

// File: tb/sv/tb_wildcard_pkg.sv
// Scoreboard for the wildcard pattern matcher testbench: a bit-accurate copy
// of the pattern store and match row, plus the queue of expected results.
// Depends on wpm_pkg for the kind codes, wildcard bytes and pattern capacity.
package tb_wildcard_pkg;
  import wpm_pkg::*;

  // The fourth kind code has no meaning and must be ignored by the block.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic matched;
    logic overflow;
  } match_result_t;

  class wildcard_scoreboard;
    logic [7:0]             pat_mem [MaxPatternDef];
    int unsigned            pat_len;
    logic [MaxPatternDef:0] row;
    logic                   overflow;
    match_result_t          expected_results [$];
    int unsigned            errors;

    function new();
      pat_len  = 0;
      row      = '0;
      row[0]   = 1'b1;
      overflow = 1'b0;
      errors   = 0;
    endfunction

    // Row for an empty text: bit k is set while the first k bytes are all '*'.
    function void load_start_row();
      logic        all_star;
      int unsigned j;
      all_star = 1'b1;
      row      = '0;
      row[0]   = 1'b1;
      for (j = 1; j <= pat_len; j++) begin
        if (pat_mem[j-1] != STAR_BYTE) all_star = 1'b0;
        row[j] = all_star;
      end
    endfunction

    function void note_request(logic [1:0] kind, logic [7:0] sym, logic first);
      logic          diag;
      logic          left;
      logic          above;
      logic          next_bit;
      int unsigned   j;
      match_result_t res;
      case (kind)
        KIND_PATTERN: begin
          if (first) begin
            pat_len  = 0;
            overflow = 1'b0;
          end
          if (pat_len < MaxPatternDef) begin
            pat_mem[pat_len] = sym;
            pat_len++;
          end else begin
            overflow = 1'b1;
          end
          load_start_row();
        end
        KIND_TEXT: begin
          diag   = row[0];
          left   = 1'b0;
          row[0] = 1'b0;
          for (j = 1; j <= pat_len; j++) begin
            above = row[j];
            // The star test comes first, so a text '*' is still absorbed.
            if (pat_mem[j-1] == STAR_BYTE) begin
              next_bit = above | left;
            end else if (pat_mem[j-1] == ANY_BYTE || pat_mem[j-1] == sym) begin
              next_bit = diag;
            end else begin
              next_bit = 1'b0;
            end
            row[j] = next_bit;
            diag   = above;
            left   = next_bit;
          end
        end
        KIND_RESTART: begin
          load_start_row();
        end
        default: begin
        end
      endcase
      if (kind == KIND_TEXT || kind == KIND_RESTART) begin
        res.matched  = row[pat_len];
        res.overflow = overflow;
        expected_results.push_back(res);
      end
    endfunction

    function void report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void check_result(logic matched, logic ovf);
      match_result_t exp_r;
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
        return;
      end
      exp_r = expected_results.pop_front();
      if (matched !== exp_r.matched) begin
        report_mismatch($sformatf("matched %b, expected %b", matched, exp_r.matched));
      end
      if (ovf !== exp_r.overflow) begin
        report_mismatch($sformatf("pattern_overflow %b, expected %b", ovf,
                                  exp_r.overflow));
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

endpackage

// File: tb/sv/tb_top.sv
// Top level of the wildcard pattern matcher testbench: clock, reset, request
// drivers, result monitor and the directed and random stimulus.
// Depends on wpm_pkg, tb_wildcard_pkg and the wildcard_pattern_matcher RTL.
module tb_top;
  import wpm_pkg::*;
  import tb_wildcard_pkg::*;

  // The slowest item is a sweep over a full pattern; the limit allows for
  // about a thousand such items with long stalls on both sides, many times over.
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES  = 300;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] kind_i;
  logic [7:0] symbol_i;
  logic       first_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       matched_o;
  logic       pattern_overflow_o;

  wildcard_scoreboard sb;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned requests_sent = 0;
  int unsigned cycle_count   = 0;
  bit          hold_off_req  = 1'b0;

  // Pattern as the stimulus generator believes it to be, and the text under
  // construction. Both are only used to shape the stimulus.
  logic [7:0] pattern_bytes [$];
  logic [7:0] text_bytes [$];

  wildcard_pattern_matcher uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .kind_i             (kind_i),
    .symbol_i           (symbol_i),
    .first_i            (first_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .matched_o          (matched_o),
    .pattern_overflow_o (pattern_overflow_o)
  );

  always #1 clk_i = ~clk_i;

  // Both handshakes are sampled in the active region of the rising edge,
  // whilst every driver updates in the nonblocking region, so the order of
  // processes within the time step does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(kind_i, symbol_i, first_i);
      if (out_valid_o && out_ready_i) sb.check_result(matched_o, pattern_overflow_o);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Result side. Ready is redrawn every cycle from the current idle rate. On
  // request the receiver holds off for a long stretch, counted here, so that
  // the block fills up and must refuse further requests.
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i  <= 1'b0;
        hold_off_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Mostly a small alphabet so that literal bytes line up often, with the
  // occasional arbitrary byte so that every bit of the symbol is exercised.
  function automatic logic [7:0] pick_literal();
    if ($urandom_range(99) < 85) return 8'h61 + 8'($urandom_range(2));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_pattern_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return STAR_BYTE;
    if (r < 50) return ANY_BYTE;
    return pick_literal();
  endfunction

  // Presents one request and returns once it has been accepted. Valid is left
  // high after acceptance; it is lowered only when an idle gap follows, so it
  // never takes two assignments in one time step.
  task automatic send_request(logic [1:0] kind, logic [7:0] sym, logic first);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    symbol_i   <= sym;
    first_i    <= first;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    if (kind != KIND_UNUSED) requests_sent++;
  endtask

  // Writes len pattern bytes; with fresh set the first one starts a new
  // pattern, otherwise they are appended to the current one.
  task automatic load_pattern(int unsigned len, logic fresh);
    logic [7:0]  b;
    int unsigned i;
    for (i = 0; i < len; i++) begin
      b = pick_pattern_byte();
      if (fresh && i == 0) pattern_bytes.delete();
      if (pattern_bytes.size() < MaxPatternDef) pattern_bytes.push_back(b);
      send_request(KIND_PATTERN, b, fresh && (i == 0));
    end
  endtask

  // Derives a text that matches the current pattern, spoils it now and then,
  // and streams it, usually after a restart. The ignored fields of text and
  // restart requests carry random values.
  task automatic run_text(logic with_restart);
    int unsigned r;
    text_bytes.delete();
    foreach (pattern_bytes[i]) begin
      if (pattern_bytes[i] == STAR_BYTE) begin
        repeat ($urandom_range(3)) text_bytes.push_back(pick_literal());
      end else if (pattern_bytes[i] == ANY_BYTE) begin
        text_bytes.push_back(pick_literal());
      end else begin
        text_bytes.push_back(pattern_bytes[i]);
      end
    end
    r = $urandom_range(99);
    if (r < 25 && text_bytes.size() > 0) begin
      text_bytes[$urandom_range(text_bytes.size() - 1)] = pick_literal();
    end else if (r < 35) begin
      text_bytes.push_back(pick_literal());
    end else if (r < 45 && text_bytes.size() > 0) begin
      void'(text_bytes.pop_back());
    end
    while (text_bytes.size() > 80) void'(text_bytes.pop_back());
    if (with_restart) begin
      send_request(KIND_RESTART, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
    foreach (text_bytes[i]) send_request(KIND_TEXT, text_bytes[i], 1'($urandom_range(1)));
  endtask

  // Random episodes: a pattern (usually new, sometimes appended to the old
  // one), then a few texts against it, with unused-kind noise in between.
  // Most patterns are short; a few reach capacity and overflow it.
  task automatic random_phase(int unsigned goal, logic force_long);
    int unsigned len;
    int unsigned target;
    logic        fresh;
    logic        long_next;
    long_next = force_long;
    target    = requests_sent + goal;
    while (requests_sent < target) begin
      if ($urandom_range(99) < 4) begin
        send_request(KIND_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        if (long_next) begin
          len = MaxPatternDef + 2;
        end else if ($urandom_range(99) < 6) begin
          len = $urandom_range(MaxPatternDef + 4, MaxPatternDef - 4);
        end else begin
          len = $urandom_range(8, 1);
        end
        fresh     = long_next || ($urandom_range(99) < 85);
        long_next = 1'b0;
        load_pattern(len, fresh);
        repeat ($urandom_range(4, 1)) run_text($urandom_range(99) < 85);
      end
    end
  endtask

  initial begin
    sb = new();
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    kind_i     <= KIND_PATTERN;
    symbol_i   <= 8'h00;
    first_i    <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 34;
    recv_idle_pct = 49;

    // Directed part. With the empty pattern left by reset only the empty
    // text matches, and an unused kind must change nothing.
    send_request(KIND_RESTART, 8'h00, 1'b0);
    send_request(KIND_TEXT, 8'h00, 1'b0);
    send_request(KIND_TEXT, 8'hFF, 1'b1);
    send_request(KIND_UNUSED, 8'hFF, 1'b1);
    // A pattern write rebuilds the row, so text may follow without a restart;
    // a text '*' must still be treated as a plain byte against a pattern '*'.
    send_request(KIND_PATTERN, STAR_BYTE, 1'b1);
    send_request(KIND_TEXT, STAR_BYTE, 1'b0);
    send_request(KIND_PATTERN, ANY_BYTE, 1'b0);
    send_request(KIND_RESTART, 8'hFF, 1'b1);
    send_request(KIND_TEXT, 8'h00, 1'b0);
    send_request(KIND_TEXT, 8'hFF, 1'b0);
    // A single literal, with an unused kind carrying first in between.
    send_request(KIND_PATTERN, 8'h61, 1'b1);
    send_request(KIND_UNUSED, 8'h61, 1'b1);
    send_request(KIND_TEXT, 8'h61, 1'b0);
    send_request(KIND_TEXT, 8'h61, 1'b0);
    // All-star prefix: the restart row must carry the match through the stars.
    send_request(KIND_PATTERN, STAR_BYTE, 1'b1);
    send_request(KIND_PATTERN, STAR_BYTE, 1'b0);
    send_request(KIND_RESTART, 8'h00, 1'b0);
    send_request(KIND_PATTERN, 8'h62, 1'b0);
    send_request(KIND_TEXT, ANY_BYTE, 1'b0);
    send_request(KIND_TEXT, 8'h62, 1'b1);
    // A pattern '?' against a text '?' and a text '*'.
    send_request(KIND_PATTERN, ANY_BYTE, 1'b1);
    send_request(KIND_TEXT, ANY_BYTE, 1'b0);
    send_request(KIND_RESTART, 8'h00, 1'b0);
    send_request(KIND_TEXT, STAR_BYTE, 1'b0);

    // Random part in three idling regimes. The first opens with a long
    // hold-off on the result side and a pattern that overruns the store.
    hold_off_req = 1'b1;
    random_phase(217, 1'b1);
    send_idle_pct = 49;
    recv_idle_pct = 34;
    random_phase(217, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(216, 1'b0);
    in_valid_i <= 1'b0;

    // Wait for the outstanding results, then give any stray result time to
    // show itself.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
sv/wpm_pkg.sv
sv/wpm_cell.sv
sv/wildcard_pattern_matcher.sv
sv/wpm_checker.sv
tb/sv/tb_wildcard_pkg.sv
tb/sv/tb_top.sv
